// ----- src/ntszm_pkg.sv -----
// Package for the note-to-sample zone mapper.
// Holds the sequencer state type and the fixed field constants; no dependencies.
package ntszm_pkg;

    // Generator opcodes
    localparam logic [15:0] OP_SAMPLE = 16'd48;
    localparam logic [15:0] OP_NOTE   = 16'd41;

    // Request kinds
    localparam logic [1:0] KIND_GEN   = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    localparam int NOTES     = 128;
    localparam int SAMPLE_W  = 16;
    localparam int KEY_W     = 7;
    localparam int ZONE_W    = SAMPLE_W + 2 * KEY_W;
    localparam int SCR_W     = SAMPLE_W + KEY_W;
    localparam logic [6:0] LAST_NOTE = 7'd127;

    typedef enum logic [3:0] {
        S_IDLE,
        S_QSCAN,
        S_QRD,
        S_QDATA,
        S_BRD,
        S_BCMP,
        S_BNOTE,
        S_ZRD,
        S_ZWR,
        S_RESP
    } state_t;

endpackage

// ----- src/note_to_sample_zone_mapper_unit.sv -----
// Note-to-sample zone mapper: pair store, nearest-pair build sequencer and zone map.
// Depends on ntszm_pkg for the state type and constants.
//
// A query walks the zone flags to find the lowest program with zones when the
// requested program has none. A build steps the single distance compare unit
// over every stored pair for every note.
// Reset clears the sequencer, pair count, current sample and zone flags; the
// pair store, scratch and zone map memories hold undefined data until written.
module note_to_sample_zone_mapper_unit
    import ntszm_pkg::*;
#(
    parameter int PAIR_DEPTH = 256,
    parameter int PROGRAMS   = 128
)(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          kind,
    input  logic [6:0]          program_req,
    input  logic [15:0]         gen_op,
    input  logic [15:0]         gen_value,
    input  logic [7:0]          note,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                found,
    output logic [15:0]         sample_index,
    output logic [6:0]          key_low,
    output logic [6:0]          key_high,
    output logic [7:0]          zone_total
);

    localparam int PAW       = $clog2(PAIR_DEPTH);
    localparam int PCW       = $clog2(PAIR_DEPTH + 1);
    localparam int PW        = (PROGRAMS > 1) ? $clog2(PROGRAMS) : 1;
    localparam int MAP_DEPTH = PROGRAMS * NOTES;
    localparam int MAP_AW    = $clog2(MAP_DEPTH);

    state_t state_reg, state_next;

    logic [15:0]         sample_count_reg, sample_count_next;
    logic [15:0]         cur_sample_reg, cur_sample_next;
    logic                cur_valid_reg, cur_valid_next;
    logic [PCW-1:0]      pair_count_reg, pair_count_next;
    logic [PROGRAMS-1:0] has_zones_reg, has_zones_next;
    logic [6:0]          prog_reg, prog_next;
    logic [6:0]          qnote_reg, qnote_next;
    logic [PW-1:0]       q_reg, q_next;
    logic [6:0]          n_reg, n_next;
    logic [PAW-1:0]      m_reg, m_next;
    logic [7:0]          best_d_reg, best_d_next;
    logic [15:0]         best_s_reg, best_s_next;
    logic                exp_reg, exp_next;
    logic [15:0]         exp_s_reg, exp_s_next;
    logic [15:0]         prev_s_reg, prev_s_next;
    logic [6:0]          lo_reg, lo_next;
    logic [6:0]          next_lo_reg, next_lo_next;
    logic [6:0]          hi_reg, hi_next;
    logic [7:0]          zc_reg, zc_next;

    logic                res_found_reg, res_found_next;
    logic [15:0]         res_sample_reg, res_sample_next;
    logic [6:0]          res_lo_reg, res_lo_next;
    logic [6:0]          res_hi_reg, res_hi_next;
    logic [7:0]          res_zc_reg, res_zc_next;

    logic                out_valid_reg, out_valid_next;
    logic                found_reg, found_next;
    logic [15:0]         sample_reg, sample_next;
    logic [6:0]          key_low_reg, key_low_next;
    logic [6:0]          key_high_reg, key_high_next;
    logic [7:0]          zone_total_reg, zone_total_next;

    // Memories
    logic [SCR_W-1:0]  pair_mem [PAIR_DEPTH];
    logic [SCR_W-1:0]  pair_rd_reg;
    logic              pair_wr_en;
    logic [SCR_W-1:0]  scr_mem [NOTES];
    logic [SCR_W-1:0]  scr_rd_reg;
    logic              scr_wr_en;
    logic [SCR_W-1:0]  scr_wr_data;
    logic [ZONE_W-1:0] map_mem [MAP_DEPTH];
    logic [ZONE_W-1:0] map_rd_reg;
    logic              map_wr_en;
    logic [ZONE_W-1:0] map_wr_data;
    logic [MAP_AW-1:0] map_raddr;
    logic [MAP_AW-1:0] map_waddr;

    logic              in_acc;
    logic              out_free;
    logic              prog_ok;
    logic              last_pair;
    logic [6:0]        pn;
    logic [15:0]       ps;
    logic [6:0]        key_dist;
    logic [15:0]       note_s;
    logic              new_run;
    logic [6:0]        run_lo;
    logic [6:0]        run_hi;

    // Handshake and shared decode
    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;
    assign prog_ok   = ({1'b0, program_req} < 8'(PROGRAMS));
    assign last_pair = ((PCW'(m_reg) + PCW'(1)) == pair_count_reg);

    // Distance unit: one stored pair against the current note
    assign pn       = pair_rd_reg[6:0];
    assign ps       = pair_rd_reg[SCR_W-1:7];
    assign key_dist = (n_reg >= pn) ? (n_reg - pn) : (pn - n_reg);

    // Note result and run start
    assign note_s  = exp_reg ? exp_s_reg : best_s_reg;
    assign new_run = (n_reg == 7'd0) || (note_s != prev_s_reg);
    assign run_lo  = new_run ? n_reg : lo_reg;
    assign run_hi  = ((n_reg == LAST_NOTE) || (next_lo_reg != scr_rd_reg[6:0]))
                     ? n_reg : hi_reg;

    assign scr_wr_data = {note_s, run_lo};
    assign map_wr_data = {scr_rd_reg[SCR_W-1:7], scr_rd_reg[6:0], run_hi};
    assign map_raddr   = MAP_AW'({q_reg, qnote_reg});
    assign map_waddr   = MAP_AW'({prog_reg[PW-1:0], n_reg});

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (kind == KIND_END)
                    begin
                        if (prog_ok && (pair_count_reg != '0))
                            state_next = S_BRD;
                        else
                            state_next = S_RESP;
                    end
                    else if (kind == KIND_QUERY)
                    begin
                        if (!prog_ok)
                            state_next = S_RESP;
                        else if (has_zones_reg[program_req[PW-1:0]])
                            state_next = S_QRD;
                        else
                            state_next = S_QSCAN;
                    end
                end
            end
            S_QSCAN:
            begin
                if (has_zones_reg[q_reg])
                    state_next = S_QRD;
                else if (q_reg == PW'(PROGRAMS - 1))
                    state_next = S_RESP;
            end
            S_QRD:   state_next = S_QDATA;
            S_QDATA: state_next = S_RESP;
            S_BRD:   state_next = S_BCMP;
            S_BCMP:  state_next = last_pair ? S_BNOTE : S_BRD;
            S_BNOTE: state_next = (n_reg == LAST_NOTE) ? S_ZRD : S_BRD;
            S_ZRD:   state_next = S_ZWR;
            S_ZWR:   state_next = (n_reg == 7'd0) ? S_RESP : S_ZRD;
            S_RESP:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        sample_count_next = sample_count_reg;
        cur_sample_next   = cur_sample_reg;
        cur_valid_next    = cur_valid_reg;
        pair_count_next   = pair_count_reg;
        has_zones_next    = has_zones_reg;
        prog_next         = prog_reg;
        qnote_next        = qnote_reg;
        q_next            = q_reg;
        n_next            = n_reg;
        m_next            = m_reg;
        best_d_next       = best_d_reg;
        best_s_next       = best_s_reg;
        exp_next          = exp_reg;
        exp_s_next        = exp_s_reg;
        prev_s_next       = prev_s_reg;
        lo_next           = lo_reg;
        next_lo_next      = next_lo_reg;
        hi_next           = hi_reg;
        zc_next           = zc_reg;
        res_found_next    = res_found_reg;
        res_sample_next   = res_sample_reg;
        res_lo_next       = res_lo_reg;
        res_hi_next       = res_hi_reg;
        res_zc_next       = res_zc_reg;
        out_valid_next    = out_valid_reg && out_stall;
        found_next        = found_reg;
        sample_next       = sample_reg;
        key_low_next      = key_low_reg;
        key_high_next     = key_high_reg;
        zone_total_next   = zone_total_reg;
        pair_wr_en        = 1'b0;
        scr_wr_en         = 1'b0;
        map_wr_en         = 1'b0;

        // Take the sample count register
        if (cfg_valid && cfg_ready)
            sample_count_next = cfg_data;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    res_found_next  = 1'b0;
                    res_sample_next = '0;
                    res_lo_next     = '0;
                    res_hi_next     = '0;
                    res_zc_next     = '0;
                    prog_next       = program_req;
                    qnote_next      = note[7] ? 7'd0 : note[6:0];
                    q_next          = '0;
                    n_next          = '0;
                    m_next          = '0;
                    best_d_next     = 8'hFF;
                    exp_next        = 1'b0;
                    zc_next         = '0;
                    if (kind == KIND_GEN)
                    begin
                        // Select a sample or append a pair
                        if ((gen_op == OP_SAMPLE) && (gen_value < sample_count_reg))
                        begin
                            cur_sample_next = gen_value;
                            cur_valid_next  = 1'b1;
                        end
                        else if ((gen_op == OP_NOTE) && cur_valid_reg
                                 && (gen_value < 16'(NOTES))
                                 && (pair_count_reg < PCW'(PAIR_DEPTH)))
                        begin
                            pair_wr_en      = 1'b1;
                            pair_count_next = pair_count_reg + PCW'(1);
                        end
                    end
                    else if (kind == KIND_END)
                    begin
                        // Empty programs and bad program numbers finish at once
                        if (!(prog_ok && (pair_count_reg != '0)))
                        begin
                            if (prog_ok)
                                has_zones_next[program_req[PW-1:0]] = 1'b0;
                            pair_count_next = '0;
                            cur_valid_next  = 1'b0;
                        end
                    end
                    else if (kind == KIND_QUERY)
                    begin
                        q_next = program_req[PW-1:0];
                        if (prog_ok && !has_zones_reg[program_req[PW-1:0]])
                            q_next = '0;
                    end
                end
            end
            S_QSCAN:
            begin
                // Walk the zone flags for the lowest program that has zones
                if (!has_zones_reg[q_reg] && (q_reg != PW'(PROGRAMS - 1)))
                    q_next = q_reg + PW'(1);
            end
            S_QRD:
            begin
            end
            S_QDATA:
            begin
                res_found_next  = 1'b1;
                res_sample_next = map_rd_reg[ZONE_W-1:14];
                res_lo_next     = map_rd_reg[13:7];
                res_hi_next     = map_rd_reg[6:0];
            end
            S_BRD:
            begin
            end
            S_BCMP:
            begin
                // Latest exact pair wins; earliest nearest pair wins
                if (key_dist == 7'd0)
                begin
                    exp_next   = 1'b1;
                    exp_s_next = ps;
                end
                if ({1'b0, key_dist} < best_d_reg)
                begin
                    best_d_next = {1'b0, key_dist};
                    best_s_next = ps;
                end
                if (!last_pair)
                    m_next = m_reg + PAW'(1);
            end
            S_BNOTE:
            begin
                // Store the note's sample and run start, count zones
                scr_wr_en   = 1'b1;
                prev_s_next = note_s;
                lo_next     = run_lo;
                if (new_run)
                    zc_next = zc_reg + 8'd1;
                m_next      = '0;
                best_d_next = 8'hFF;
                exp_next    = 1'b0;
                if (n_reg != LAST_NOTE)
                    n_next = n_reg + 7'd1;
            end
            S_ZRD:
            begin
            end
            S_ZWR:
            begin
                // Write the zone map from the top note down
                map_wr_en    = 1'b1;
                next_lo_next = scr_rd_reg[6:0];
                hi_next      = run_hi;
                if (n_reg == 7'd0)
                begin
                    has_zones_next[prog_reg[PW-1:0]] = 1'b1;
                    res_found_next  = 1'b1;
                    res_zc_next     = zc_reg;
                    pair_count_next = '0;
                    cur_valid_next  = 1'b0;
                end
                else
                begin
                    n_next = n_reg - 7'd1;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    found_next      = res_found_reg;
                    sample_next     = res_sample_reg;
                    key_low_next    = res_lo_reg;
                    key_high_next   = res_hi_reg;
                    zone_total_next = res_zc_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            sample_count_reg <= '0;
            cur_sample_reg   <= '0;
            cur_valid_reg    <= 1'b0;
            pair_count_reg   <= '0;
            has_zones_reg    <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            sample_count_reg <= sample_count_next;
            cur_sample_reg   <= cur_sample_next;
            cur_valid_reg    <= cur_valid_next;
            pair_count_reg   <= pair_count_next;
            has_zones_reg    <= has_zones_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        prog_reg       <= prog_next;
        qnote_reg      <= qnote_next;
        q_reg          <= q_next;
        n_reg          <= n_next;
        m_reg          <= m_next;
        best_d_reg     <= best_d_next;
        best_s_reg     <= best_s_next;
        exp_reg        <= exp_next;
        exp_s_reg      <= exp_s_next;
        prev_s_reg     <= prev_s_next;
        lo_reg         <= lo_next;
        next_lo_reg    <= next_lo_next;
        hi_reg         <= hi_next;
        zc_reg         <= zc_next;
        res_found_reg  <= res_found_next;
        res_sample_reg <= res_sample_next;
        res_lo_reg     <= res_lo_next;
        res_hi_reg     <= res_hi_next;
        res_zc_reg     <= res_zc_next;
        found_reg      <= found_next;
        sample_reg     <= sample_next;
        key_low_reg    <= key_low_next;
        key_high_reg   <= key_high_next;
        zone_total_reg <= zone_total_next;
    end

    // Pair store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (pair_wr_en)
            pair_mem[pair_count_reg[PAW-1:0]] <= {cur_sample_reg, gen_value[6:0]};
        pair_rd_reg <= pair_mem[m_reg];
    end

    // Per-note scratch
    always_ff @(posedge clk)
    begin
        if (scr_wr_en)
            scr_mem[n_reg] <= scr_wr_data;
        scr_rd_reg <= scr_mem[n_reg];
    end

    // Zone map, one entry per program and note
    always_ff @(posedge clk)
    begin
        if (map_wr_en)
            map_mem[map_waddr] <= map_wr_data;
        map_rd_reg <= map_mem[map_raddr];
    end

    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign sample_index = sample_reg;
    assign key_low      = key_low_reg;
    assign key_high     = key_high_reg;
    assign zone_total   = zone_total_reg;

    // Pair count stays within the store
    a_pair_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pair_count_reg <= PCW'(PAIR_DEPTH))
        else $error("pair count beyond store depth");

    // The compare unit only runs with stored pairs
    a_cmp_pairs: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BCMP) |-> (pair_count_reg != '0))
        else $error("pair compare without pairs");

    // A finished build has made at least one zone
    a_build_zones: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_ZWR) && (n_reg == 7'd0)) |-> (zc_reg != 8'd0))
        else $error("build finished without zones");

    // A new response only follows the response state
    a_resp_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_RESP))
        else $error("response raised outside response state");

endmodule

// ----- test/note_to_sample_zone_mapper_unit_tb.sv -----
// Self-checking testbench for note_to_sample_zone_mapper_unit.
// Needs ntszm_pkg and the unit; predicts each result in-line and compares it per field.
`timescale 1ns / 100ps

module note_to_sample_zone_mapper_unit_tb;
    import ntszm_pkg::*;

    localparam int PAIR_MAX   = 256;
    localparam int PROG_MAX   = 128;
    localparam int CYCLE_CAP  = 4000000;
    localparam logic [1:0] KIND_SPARE = 2'd3;

    typedef struct packed {
        logic        found;
        logic [15:0] sample;
        logic [6:0]  lo;
        logic [6:0]  hi;
        logic [7:0]  zones;
    } zone_answer_t;

    typedef struct packed {
        logic [15:0] sample;
        logic [6:0]  lo;
        logic [6:0]  hi;
    } zone_entry_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  kind;
    logic [6:0]  program_req;
    logic [15:0] gen_op;
    logic [15:0] gen_value;
    logic [7:0]  note;
    logic        out_valid;
    logic        out_stall;
    logic        found;
    logic [15:0] sample_index;
    logic [6:0]  key_low;
    logic [6:0]  key_high;
    logic [7:0]  zone_total;

    // Mirror of the mapper state
    logic [15:0] sample_limit;
    logic [15:0] pair_sample_m [PAIR_MAX];
    logic [6:0]  pair_note_m [PAIR_MAX];
    int          pair_total;
    logic [15:0] sel_sample;
    bit          sel_ok;
    zone_entry_t zone_map [PROG_MAX][128];
    int          zones_built [PROG_MAX];
    bit          has_zones [PROG_MAX];

    zone_answer_t awaited_answers[$];

    int  mismatches;
    int  requests_sent;
    int  answers_seen;
    int  builds_seen;
    int  cycles;
    int  burst_left;
    bit  sender_gaps;
    int  stall_pct;
    int  hold_left;
    int  hold_request;

    note_to_sample_zone_mapper_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .program_req  (program_req),
        .gen_op       (gen_op),
        .gen_value    (gen_value),
        .note         (note),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .found        (found),
        .sample_index (sample_index),
        .key_low      (key_low),
        .key_high     (key_high),
        .zone_total   (zone_total)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Fill the 128-note map from the stored pairs and cut it into zones
    function automatic int build_zone_map(int p);
        logic [15:0] smp [128];
        bit          named [128];
        int          best;
        int          best_d;
        int          d;
        int          z;
        int          start;
        logic [15:0] cur;
        for (int n = 0; n < 128; n++)
            named[n] = 1'b0;
        if (pair_total == 0)
        begin
            has_zones[p] = 1'b0;
            return 0;
        end
        for (int m = 0; m < pair_total; m++)
        begin
            named[pair_note_m[m]] = 1'b1;
            smp[pair_note_m[m]] = pair_sample_m[m];
        end
        for (int n = 0; n < 128; n++)
        begin
            if (!named[n])
            begin
                best = 0;
                best_d = 1000;
                for (int m = 0; m < pair_total; m++)
                begin
                    d = (n >= pair_note_m[m]) ? n - pair_note_m[m] : pair_note_m[m] - n;
                    if (d < best_d)
                    begin
                        best_d = d;
                        best = m;
                    end
                end
                smp[n] = pair_sample_m[best];
            end
        end
        z = 0;
        start = 0;
        cur = smp[0];
        for (int n = 1; n <= 128; n++)
        begin
            if (n == 128 || smp[n] != cur)
            begin
                zone_map[p][z] = '{cur, 7'(start), 7'(n - 1)};
                z++;
                if (n < 128)
                begin
                    cur = smp[n];
                    start = n;
                end
            end
        end
        zones_built[p] = z;
        has_zones[p] = 1'b1;
        return z;
    endfunction

    // Advance the mirror by one accepted request and queue its answer
    task automatic predict_mapper_item(logic [1:0] k, logic [6:0] p, logic [15:0] op,
                                       logic [15:0] v, logic [7:0] nt);
        zone_answer_t ans;
        int           q;
        int           zc;
        zone_entry_t  e;
        ans = '0;
        if (k == KIND_GEN)
        begin
            if (op == OP_SAMPLE)
            begin
                if (v < sample_limit)
                begin
                    sel_sample = v;
                    sel_ok = 1'b1;
                end
            end
            else if (op == OP_NOTE)
            begin
                if (sel_ok && v < 128 && pair_total < PAIR_MAX)
                begin
                    pair_sample_m[pair_total] = sel_sample;
                    pair_note_m[pair_total] = v[6:0];
                    pair_total++;
                end
            end
        end
        else if (k == KIND_END)
        begin
            zc = build_zone_map(p);
            pair_total = 0;
            sel_ok = 1'b0;
            ans.found = (zc > 0);
            ans.zones = 8'(zc);
            awaited_answers.push_back(ans);
        end
        else if (k == KIND_QUERY)
        begin
            q = p;
            if (!has_zones[q])
            begin
                q = PROG_MAX;
                for (int i = PROG_MAX - 1; i >= 0; i--)
                    if (has_zones[i])
                        q = i;
            end
            if (q < PROG_MAX)
            begin
                e = zone_map[q][0];
                if (nt < 128)
                begin
                    for (int z = 0; z < zones_built[q]; z++)
                    begin
                        if (nt >= zone_map[q][z].lo && nt <= zone_map[q][z].hi)
                        begin
                            e = zone_map[q][z];
                            break;
                        end
                    end
                end
                ans.found = 1'b1;
                ans.sample = e.sample;
                ans.lo = e.lo;
                ans.hi = e.hi;
            end
            awaited_answers.push_back(ans);
        end
    endtask

    // Check each answer against the oldest awaited one; watch for a hang
    always @(posedge clk)
    begin
        zone_answer_t w;
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            answers_seen <= answers_seen + 1;
            if (awaited_answers.size() == 0)
            begin
                $error("unexpected answer: found %0d sample %0d", found, sample_index);
                mismatches++;
            end
            else
            begin
                w = awaited_answers.pop_front();
                if (found !== w.found)
                begin
                    $error("found: expected %0d, actual %0d", w.found, found);
                    mismatches++;
                end
                if (sample_index !== w.sample)
                begin
                    $error("sample_index: expected %0d, actual %0d", w.sample, sample_index);
                    mismatches++;
                end
                if (key_low !== w.lo)
                begin
                    $error("key_low: expected %0d, actual %0d", w.lo, key_low);
                    mismatches++;
                end
                if (key_high !== w.hi)
                begin
                    $error("key_high: expected %0d, actual %0d", w.hi, key_high);
                    mismatches++;
                end
                if (zone_total !== w.zones)
                begin
                    $error("zone_total: expected %0d, actual %0d", w.zones, zone_total);
                    mismatches++;
                end
            end
        end
    end

    // Receiver: long hold-offs on request, otherwise a random stall pattern
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left <= hold_request;
            hold_request <= 0;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Offer one request and hold it until accepted
    task automatic send_request(logic [1:0] k, logic [6:0] p, logic [15:0] op,
                                logic [15:0] v, logic [7:0] nt);
        if (sender_gaps)
        begin
            if (burst_left == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                burst_left = $urandom_range(1, 12);
            end
            else
                burst_left--;
        end
        in_valid    <= 1'b1;
        kind        <= k;
        program_req <= p;
        gen_op      <= op;
        gen_value   <= v;
        note        <= nt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_mapper_item(k, p, op, v, nt);
        requests_sent++;
    endtask

    // Drop valid and wait for every awaited answer, then let the block settle
    task automatic drain_requests();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited_answers.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_sample_limit(logic [15:0] v);
        drain_requests();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sample_limit = v;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_sample();
        if (sample_limit == 0)
            return 16'($urandom);
        return 16'($urandom_range(0, sample_limit - 1));
    endfunction

    task automatic select_sample(logic [15:0] s);
        send_request(KIND_GEN, 7'($urandom), OP_SAMPLE, s, 8'($urandom));
    endtask

    task automatic assign_note(logic [15:0] n);
        send_request(KIND_GEN, 7'($urandom), OP_NOTE, n, 8'($urandom));
    endtask

    task automatic end_program(logic [6:0] p);
        send_request(KIND_END, p, 16'($urandom), 16'($urandom), 8'($urandom));
    endtask

    task automatic query_note(logic [6:0] p, logic [7:0] nt);
        send_request(KIND_QUERY, p, 16'($urandom), 16'($urandom), nt);
    endtask

    // Edge cases: empty map, ignored records, overrides, notes above 127
    task automatic test_directed();
        write_sample_limit(16'd4);
        query_note(7'd0, 8'd10);
        end_program(7'd3);
        assign_note(16'd20);
        select_sample(16'd4);
        assign_note(16'd21);
        select_sample(16'd3);
        assign_note(16'd0);
        assign_note(16'd127);
        assign_note(16'd200);
        send_request(KIND_GEN, 7'd0, 16'd7, 16'd1, 8'd0);
        send_request(KIND_SPARE, 7'd5, OP_NOTE, 16'd9, 8'd9);
        select_sample(16'd1);
        assign_note(16'd64);
        select_sample(16'd2);
        assign_note(16'd64);
        end_program(7'd5);
        query_note(7'd5, 8'd0);
        query_note(7'd5, 8'd64);
        query_note(7'd5, 8'd127);
        query_note(7'd5, 8'd200);
        query_note(7'd0, 8'd255);
        select_sample(16'd0);
        assign_note(16'd50);
        end_program(7'd127);
        query_note(7'd127, 8'd3);
    endtask

    // Overfill the pair store so the tail of the pairs is dropped
    task automatic test_full_store();
        write_sample_limit(16'hFFFF);
        for (int i = 0; i < PAIR_MAX + 4; i++)
        begin
            if (i % 32 == 0)
                select_sample(16'hFFFE - 16'(i));
            assign_note(16'($urandom_range(0, 127)));
        end
        end_program(7'd9);
        for (int i = 0; i < 6; i++)
            query_note(7'd9, 8'($urandom));
    endtask

    // One program: mostly well-formed records with some noise, then queries
    task automatic random_program();
        int          npairs;
        logic [6:0]  p;
        npairs = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
        p = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(0, 15));
        for (int i = 0; i < npairs; i++)
        begin
            case ($urandom_range(0, 9))
                0: send_request(KIND_GEN, 7'($urandom), 16'($urandom), 16'($urandom),
                                8'($urandom));
                1: assign_note(16'($urandom_range(128, 65535)));
                2: select_sample(16'($urandom_range(sample_limit, 65535)));
                3: send_request(KIND_SPARE, 7'($urandom), 16'($urandom), 16'($urandom),
                                8'($urandom));
                default:
                begin
                    if (i == 0 || $urandom_range(0, 1))
                        select_sample(pick_sample());
                    assign_note(16'($urandom_range(0, 127)));
                end
            endcase
        end
        // Now and then skip the end so pairs carry into the next program
        if ($urandom_range(0, 19) != 0)
            end_program(p);
        repeat ($urandom_range(1, 5))
            query_note(($urandom_range(0, 1) ? p : 7'($urandom)), 8'($urandom));
    endtask

    task automatic test_random(int count);
        int goal;
        goal = requests_sent + count;
        while (requests_sent < goal)
        begin
            random_program();
            // Pause until every answer is in, now and then
            if ($urandom_range(0, 29) == 0)
                drain_requests();
        end
    endtask

    // Hold the receiver off so the block fills and stalls its input
    task automatic test_backpressure();
        hold_request = 600;
        for (int i = 0; i < 30; i++)
            query_note(7'($urandom), 8'($urandom));
        drain_requests();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        kind = '0;
        program_req = '0;
        gen_op = '0;
        gen_value = '0;
        note = '0;
        out_stall = 1'b0;
        sample_limit = '0;
        pair_total = 0;
        sel_sample = '0;
        sel_ok = 1'b0;
        for (int i = 0; i < PROG_MAX; i++)
        begin
            has_zones[i] = 1'b0;
            zones_built[i] = 0;
        end
        mismatches = 0;
        requests_sent = 0;
        answers_seen = 0;
        cycles = 0;
        burst_left = 0;
        sender_gaps = 1'b0;
        stall_pct = 0;
        hold_left = 0;
        hold_request = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_store();
        sender_gaps = 1'b1;
        stall_pct = 30;
        write_sample_limit(16'd0);
        test_random(150);
        write_sample_limit(16'd1);
        test_random(300);
        test_backpressure();
        sender_gaps = 1'b0;
        stall_pct = 0;
        write_sample_limit(16'hFFFF);
        test_random(400);
        sender_gaps = 1'b1;
        stall_pct = 50;
        write_sample_limit(16'($urandom_range(2, 40)));
        test_random(400);
        write_sample_limit(16'($urandom));
        test_random(300);
        drain_requests();

        $display("covered %0d requests, %0d answers checked", requests_sent, answers_seen);
        $display("sample limits 0, 1, 4, max and random; full pair store; long hold-off");
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
